>>> design/titl_pkg.sv
// Shared types and constants for the timed interval table lookup block.
package titl_pkg;

  // Command codes
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_FINALIZE = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISPLAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 1'd1;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned IDX_W  = 8;

  localparam logic [TIME_W-1:0] MAX_DISPLAY_RESET = 32'd10000;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] entry_start;
    logic [TIME_W-1:0] entry_end;
    logic [TIME_W-1:0] position_ms;
  } req_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [IDX_W-1:0] entry_index;
  } rsp_t;

endpackage

>>> design/titl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module titl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/timed_interval_table_lookup.sv
// Timing: one item at a time. Clear and append pass straight from idle to the
// result state. A query walks the table backwards from the newest entry,
// one entry per cycle through the registered read port of the start and end
// memories, until it meets a start at or below the adjusted position or passes
// the oldest entry. Finalize visits each entry in a read and an evaluate state;
// an entry other than the last whose end must be repaired also scans later
// starts, each in a read and an evaluate state through the same port. Entry
// times live in two RAMs of MAX_ENTRIES words; only entries below the fill
// count are ever evaluated, so no clearing pass is needed after reset. A result
// may wait on rsp_stall while the next item is already being taken in and
// worked on.
module timed_interval_table_lookup #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  titl_pkg::req_t                        req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output titl_pkg::rsp_t                        rsp,
  input  logic                                  cfg_we,
  input  logic [titl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [titl_pkg::TIME_W-1:0]           cfg_data
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW = titl_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QRY,
    S_F_RD_I,
    S_F_EV_I,
    S_F_RD_J,
    S_F_EV_J,
    S_DONE
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [TW-1:0]         max_display;
  logic signed [TW-1:0]  offset;
  titl_pkg::rsp_t        res;

  // Query walk registers
  logic signed [TW+1:0]  adj;
  logic [CW-1:0]         q_ptr;
  logic                  q_more;
  logic                  q_pend;
  logic [AW-1:0]         q_pidx;

  // Finalize registers
  logic [CW-1:0]         fi;
  logic [CW-1:0]         fj;
  logic [TW-1:0]         s_reg;
  logic [TW-1:0]         limit_reg;

  // Memory ports
  logic [AW-1:0]         rd_addr;
  logic [TW-1:0]         start_rdata;
  logic [TW-1:0]         end_rdata;
  logic                  start_we;
  logic                  end_we;
  logic [AW-1:0]         end_waddr;
  logic [TW-1:0]         end_wdata;

  logic                  accept;
  logic                  full;
  logic [TW:0]           cap_sum;
  logic [TW-1:0]         cap_now;
  logic signed [TW+1:0]  start_ext;
  logic signed [TW+1:0]  end_ext;
  logic                  q_le;
  logic                  q_lt;
  logic                  later_gt;
  logic [TW-1:0]         next_end;
  logic [CW-1:0]         fi_inc;
  logic [CW-1:0]         fj_inc;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(MAX_ENTRIES));

  // Compare and cap logic on the read data
  assign start_ext = $signed({2'b00, start_rdata});
  assign end_ext   = $signed({2'b00, end_rdata});
  assign q_le      = (start_ext <= adj);
  assign q_lt      = (adj < end_ext);
  assign cap_sum   = {1'b0, start_rdata} + {1'b0, max_display};
  assign cap_now   = cap_sum[TW] ? {TW{1'b1}} : cap_sum[TW-1:0];
  assign later_gt  = (start_rdata > s_reg);
  assign next_end  = (later_gt && (start_rdata < limit_reg)) ? start_rdata : limit_reg;
  assign fi_inc    = fi + 1'b1;
  assign fj_inc    = fj + 1'b1;

  // Read address select
  always_comb begin
    case (state)
      S_QRY:    rd_addr = q_ptr[AW-1:0];
      S_F_RD_J: rd_addr = fj[AW-1:0];
      default:  rd_addr = fi[AW-1:0];
    endcase
  end

  // Write ports: append fills both memories, finalize repairs end times
  assign start_we = accept && (req.command == titl_pkg::CMD_APPEND) && !full;

  always_comb begin
    end_we    = start_we;
    end_waddr = count[AW-1:0];
    end_wdata = req.entry_end;
    if (state == S_F_EV_I) begin
      end_we    = !(end_rdata > start_rdata) && (fi_inc == count);
      end_waddr = fi[AW-1:0];
      end_wdata = cap_now;
    end else if (state == S_F_EV_J) begin
      end_we    = later_gt || (fj_inc == count);
      end_waddr = fi[AW-1:0];
      end_wdata = next_end;
    end
  end

  titl_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (count[AW-1:0]),
    .wdata (req.entry_start),
    .raddr (rd_addr),
    .rdata (start_rdata)
  );

  titl_ram #(.WIDTH(TW), .DEPTH(MAX_ENTRIES)) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (end_waddr),
    .wdata (end_wdata),
    .raddr (rd_addr),
    .rdata (end_rdata)
  );

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      rsp_valid   <= 1'b0;
      max_display <= titl_pkg::MAX_DISPLAY_RESET;
      offset      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          titl_pkg::REG_MAX_DISPLAY: max_display <= cfg_data;
          titl_pkg::REG_OFFSET:      offset      <= $signed(cfg_data);
          default: ;
        endcase
      end

      // A new result in S_DONE takes the place of the one leaving
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            res.status      <= (req.command == titl_pkg::CMD_APPEND) && full;
            res.found       <= 1'b0;
            res.entry_index <= '0;
            case (req.command)
              titl_pkg::CMD_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              titl_pkg::CMD_APPEND: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
                state <= S_DONE;
              end
              titl_pkg::CMD_FINALIZE: begin
                fi <= '0;
                state <= (count == '0) ? S_DONE : S_F_RD_I;
              end
              titl_pkg::CMD_QUERY: begin
                adj    <= $signed({2'b00, req.position_ms}) - (TW+2)'(offset);
                q_ptr  <= count - 1'b1;
                q_more <= 1'b1;
                q_pend <= 1'b0;
                state  <= (count == '0) ? S_DONE : S_QRY;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // Backward walk, one read issued per cycle
        S_QRY: begin
          if (q_pend && q_le) begin
            res.found       <= q_lt;
            res.entry_index <= q_lt ? titl_pkg::IDX_W'(q_pidx) : '0;
            state           <= S_DONE;
          end else if (q_pend && (q_pidx == '0)) begin
            state <= S_DONE;
          end else if (q_more) begin
            q_pend <= 1'b1;
            q_pidx <= q_ptr[AW-1:0];
            q_more <= (q_ptr != '0);
            q_ptr  <= q_ptr - 1'b1;
          end
        end

        S_F_RD_I: state <= S_F_EV_I;

        // Check entry i; if its end needs repair, write the cap for the last entry or start a forward scan
        S_F_EV_I: begin
          if (end_rdata > start_rdata || fi_inc == count) begin
            fi    <= fi_inc;
            state <= (fi_inc == count) ? S_DONE : S_F_RD_I;
          end else begin
            s_reg     <= start_rdata;
            limit_reg <= cap_now;
            fj        <= fi_inc;
            state     <= S_F_RD_J;
          end
        end

        S_F_RD_J: state <= S_F_EV_J;

        // Forward scan for the first later start that is greater
        S_F_EV_J: begin
          if (later_gt || fj_inc == count) begin
            fi    <= fi_inc;
            state <= (fi_inc == count) ? S_DONE : S_F_RD_I;
          end else begin
            fj    <= fj_inc;
            state <= S_F_RD_J;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Every transfer starts work, so the sequencer leaves idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer idle after a transfer");

  // An append into a table with room grows the count by one
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == titl_pkg::CMD_APPEND && !full)
      |=> (count == $past(count) + 1'b1))
    else $error("append did not advance the count");

  // The walk only evaluates entries that were written
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QRY && q_pend) |-> (CW'(q_pidx) < count))
    else $error("query read beyond the fill count");

  // A dropped append never reports a hit
  a_status_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.status && rsp.found))
    else $error("result flags both drop and hit");
`endif

endmodule

>>> tb/sv/timed_interval_table_lookup_tb.sv
// Self-checking testbench for the timed interval table lookup block.
module timed_interval_table_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int ITEM_TARGET = 1775;

  // One row of the directed plan: a register write or a transfer
  typedef struct {
    bit                             is_cfg;
    logic [titl_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [titl_pkg::TIME_W-1:0]    reg_val;
    titl_pkg::req_t                 item;
    bit                             fixed;
    titl_pkg::rsp_t                 want;
  } step_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  titl_pkg::req_t                 req = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  titl_pkg::rsp_t                 rsp;
  logic                           cfg_we = 1'b0;
  logic [titl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [titl_pkg::TIME_W-1:0]    cfg_data = '0;

  // Sideband that travels with req: a hand-typed result for directed rows
  logic           fixed_on = 1'b0;
  titl_pkg::rsp_t fixed_rsp = '0;

  // Shadow copy of the entry table and registers
  logic [titl_pkg::TIME_W-1:0]        start_ms_tbl [TABLE_DEPTH];
  logic [titl_pkg::TIME_W-1:0]        end_ms_tbl [TABLE_DEPTH];
  int                                 fill_count = 0;
  logic [titl_pkg::TIME_W-1:0]        cfg_max_display = titl_pkg::MAX_DISPLAY_RESET;
  logic signed [titl_pkg::TIME_W-1:0] cfg_offset = '0;

  titl_pkg::rsp_t lookup_exp_q[$];
  int             items_sent = 0;
  int             results_seen = 0;
  int             err_cnt = 0;
  int unsigned    burst_left = 0;
  int unsigned    stall_phase = 0;
  int unsigned    stall_style = 0;

  timed_interval_table_lookup #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Apply one command to the shadow table and return its result
  function automatic titl_pkg::rsp_t table_step(input titl_pkg::req_t r);
    titl_pkg::rsp_t              o;
    logic [titl_pkg::TIME_W:0]   cap_sum;
    logic [titl_pkg::TIME_W-1:0] cap, nxt;
    longint                      pos_adj;
    o = '0;
    case (r.command)
      titl_pkg::CMD_CLEAR: fill_count = 0;
      titl_pkg::CMD_APPEND: begin
        if (fill_count >= TABLE_DEPTH) begin
          o.status = 1'b1;
        end else begin
          start_ms_tbl[fill_count] = r.entry_start;
          end_ms_tbl[fill_count] = r.entry_end;
          fill_count++;
        end
      end
      titl_pkg::CMD_FINALIZE: begin
        // repair ends that are not after their start
        for (int i = 0; i < fill_count; i++) begin
          if (end_ms_tbl[i] <= start_ms_tbl[i]) begin
            cap_sum = {1'b0, start_ms_tbl[i]} + {1'b0, cfg_max_display};
            cap = cap_sum[titl_pkg::TIME_W] ? 32'hFFFF_FFFF
                                            : cap_sum[titl_pkg::TIME_W-1:0];
            nxt = cap;
            for (int j = i + 1; j < fill_count; j++) begin
              if (start_ms_tbl[j] > start_ms_tbl[i]) begin
                nxt = start_ms_tbl[j];
                break;
              end
            end
            end_ms_tbl[i] = (nxt < cap) ? nxt : cap;
          end
        end
      end
      default: begin
        // exact adjusted position, may be negative or above 32 bits
        pos_adj = longint'({32'd0, r.position_ms}) - longint'(cfg_offset);
        for (int k = fill_count - 1; k >= 0; k--) begin
          if (longint'({32'd0, start_ms_tbl[k]}) <= pos_adj) begin
            if (pos_adj < longint'({32'd0, end_ms_tbl[k]})) begin
              o.found = 1'b1;
              o.entry_index = k[titl_pkg::IDX_W-1:0];
            end
            break;
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Result checking, transfer capture and register shadowing
  always @(posedge clk) begin : monitor
    titl_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (lookup_exp_q.size() == 0) begin
          $error("result transfer with nothing pending");
          err_cnt++;
        end else begin
          want = lookup_exp_q.pop_front();
          check_field("status", 8'(want.status), 8'(rsp.status));
          check_field("found", 8'(want.found), 8'(rsp.found));
          check_field("entry_index", want.entry_index, rsp.entry_index);
        end
      end
      if (req_valid && !req_stall) begin
        want = table_step(req);
        if (fixed_on)
          want = fixed_rsp;
        lookup_exp_q.push_back(want);
      end
      if (cfg_we) begin
        if (cfg_index == titl_pkg::REG_MAX_DISPLAY)
          cfg_max_display = cfg_data;
        else if (cfg_index == titl_pkg::REG_OFFSET)
          cfg_offset = cfg_data;
      end
    end
  end

  // Receiver back-pressure: a style picked for a stretch of cycles
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(50, 400);
      stall_style = $urandom_range(0, 3);
    end else begin
      stall_phase--;
    end
    case (stall_style)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 1) == 1);
      2: rsp_stall <= ((stall_phase % 16) < 11);
      default: rsp_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic titl_pkg::req_t cmd_item(input logic [1:0] c,
                                              input logic [titl_pkg::TIME_W-1:0] s,
                                              input logic [titl_pkg::TIME_W-1:0] e,
                                              input logic [titl_pkg::TIME_W-1:0] p);
    titl_pkg::req_t r;
    r.command = c;
    r.entry_start = s;
    r.entry_end = e;
    r.position_ms = p;
    return r;
  endfunction

  function automatic titl_pkg::rsp_t outcome(input int st, input int f, input int ix);
    titl_pkg::rsp_t o;
    o.status = 1'(st);
    o.found = 1'(f);
    o.entry_index = titl_pkg::IDX_W'(ix);
    return o;
  endfunction

  function automatic step_row_t fixed_row(input logic [1:0] c,
                                          input logic [titl_pkg::TIME_W-1:0] s,
                                          input logic [titl_pkg::TIME_W-1:0] e,
                                          input logic [titl_pkg::TIME_W-1:0] p,
                                          input titl_pkg::rsp_t want);
    step_row_t row;
    row = '{default: '0};
    row.item = cmd_item(c, s, e, p);
    row.fixed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic step_row_t pred_row(input logic [1:0] c,
                                         input logic [titl_pkg::TIME_W-1:0] s,
                                         input logic [titl_pkg::TIME_W-1:0] e,
                                         input logic [titl_pkg::TIME_W-1:0] p);
    step_row_t row;
    row = '{default: '0};
    row.item = cmd_item(c, s, e, p);
    return row;
  endfunction

  function automatic step_row_t reg_row(input logic [titl_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [titl_pkg::TIME_W-1:0] v);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    return row;
  endfunction

  // Drive one transfer, then idle per the burst/gap pattern
  task automatic send_item(input titl_pkg::req_t item, input logic fixed,
                           input titl_pkg::rsp_t want);
    int unsigned gap;
    req <= item;
    req_valid <= 1'b1;
    fixed_on <= fixed;
    fixed_rsp <= want;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 300);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every pending result has been returned
  task automatic drain();
    req_valid <= 1'b0;
    while (results_seen < items_sent)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [titl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [titl_pkg::TIME_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Register settings: extremes first, then random ones
  task automatic new_setting(input int pick);
    case (pick)
      0: begin
        write_reg(titl_pkg::REG_MAX_DISPLAY, 32'd0);
        write_reg(titl_pkg::REG_OFFSET, 32'd0);
      end
      1: begin
        write_reg(titl_pkg::REG_MAX_DISPLAY, 32'hFFFF_FFFF);
        write_reg(titl_pkg::REG_OFFSET, 32'h8000_0000);
      end
      2: begin
        write_reg(titl_pkg::REG_MAX_DISPLAY, 32'd1);
        write_reg(titl_pkg::REG_OFFSET, 32'h7FFF_FFFF);
      end
      3: begin
        write_reg(titl_pkg::REG_MAX_DISPLAY, titl_pkg::MAX_DISPLAY_RESET);
        write_reg(titl_pkg::REG_OFFSET, 32'hFFFF_FFFF);
      end
      default: begin
        write_reg(titl_pkg::REG_MAX_DISPLAY,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6000));
        write_reg(titl_pkg::REG_OFFSET,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000) - 1500);
      end
    endcase
  endtask

  task automatic send_noise();
    send_item(cmd_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom), 1'b0, '0);
  endtask

  // clear, a run of appends, an optional finalize, then queries around the stored starts
  task automatic run_session(input bit fill_up);
    int                          n_ent, n_qry, k;
    logic [titl_pkg::TIME_W-1:0] t, e, tgt;
    logic [titl_pkg::TIME_W-1:0] starts[$];
    n_ent = fill_up ? TABLE_DEPTH + $urandom_range(1, 8) : $urandom_range(1, 12);
    n_qry = fill_up ? 10 : $urandom_range(2, 10);
    case ($urandom_range(0, 3))
      0, 1: t = $urandom_range(0, 1000);
      2: t = 32'hFFFF_FFFF - $urandom_range(0, 60000);
      default: t = $urandom;
    endcase
    send_item(cmd_item(titl_pkg::CMD_CLEAR, $urandom, $urandom, $urandom), 1'b0, '0);
    for (int i = 0; i < n_ent; i++) begin
      case ($urandom_range(0, 9))
        0: ;  // repeated start
        1: t = t - $urandom_range(1, 200);
        default: t = t + $urandom_range(1, 3000);
      endcase
      case ($urandom_range(0, 9))
        0, 1: e = 32'd0;
        2: e = t;
        3: e = t - $urandom_range(1, 500);
        4: e = $urandom;
        5: e = 32'hFFFF_FFFF;
        default: e = t + $urandom_range(1, 4000);
      endcase
      starts.push_back(t);
      send_item(cmd_item(titl_pkg::CMD_APPEND, t, e, $urandom), 1'b0, '0);
      if ($urandom_range(0, 24) == 0)
        send_noise();
    end
    // finalize is sometimes left out to query raw ends
    if ($urandom_range(0, 7) != 0)
      send_item(cmd_item(titl_pkg::CMD_FINALIZE, $urandom, $urandom, $urandom), 1'b0, '0);
    for (int q = 0; q < n_qry; q++) begin
      k = $urandom_range(0, starts.size() - 1);
      case ($urandom_range(0, 5))
        0: tgt = starts[k] - 1;
        1: tgt = starts[k];
        2: tgt = starts[k] + $urandom_range(0, 500);
        3: tgt = starts[k] + $urandom_range(500, 12000);
        4: tgt = $urandom;
        default: tgt = $urandom_range(0, 3000);
      endcase
      send_item(cmd_item(titl_pkg::CMD_QUERY, $urandom, $urandom, tgt + cfg_offset),
                1'b0, '0);
      if ($urandom_range(0, 15) == 0)
        send_noise();
    end
  endtask

  initial begin : stimulus
    step_row_t plan[$];
    int        sess;

    // empty table, unset ends, repeated start, cap saturation, offset extremes
    plan.push_back(fixed_row(titl_pkg::CMD_QUERY, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_FINALIZE, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 100, 50, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 100, 32'hFFFF_FFFF, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 32'hFFFF_FFF0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_FINALIZE, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 0));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 99));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 100));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFE));
    plan.push_back(reg_row(titl_pkg::REG_OFFSET, 32'h8000_0000));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 0));
    plan.push_back(reg_row(titl_pkg::REG_OFFSET, 32'h7FFF_FFFF));
    plan.push_back(fixed_row(titl_pkg::CMD_QUERY, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(reg_row(titl_pkg::REG_OFFSET, 32'd0));
    // zero display time: a repaired entry can never be hit
    plan.push_back(reg_row(titl_pkg::REG_MAX_DISPLAY, 32'd0));
    plan.push_back(fixed_row(titl_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 5, 5, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 5, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_FINALIZE, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 5));
    // full display time with saturated cap
    plan.push_back(reg_row(titl_pkg::REG_MAX_DISPLAY, 32'hFFFF_FFFF));
    plan.push_back(fixed_row(titl_pkg::CMD_CLEAR, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 1, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_APPEND, 32'hFFFF_FFFF, 0, 0, outcome(0, 0, 0)));
    plan.push_back(fixed_row(titl_pkg::CMD_FINALIZE, 0, 0, 0, outcome(0, 0, 0)));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFE));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(pred_row(titl_pkg::CMD_QUERY, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].item, plan[i].fixed, plan[i].want);
      end
    end

    // random sessions, with settings changed between them while idle
    sess = 0;
    while (items_sent < ITEM_TARGET) begin
      if (sess % 9 == 4) begin
        drain();
        new_setting((sess / 9) % 6);
      end else if ($urandom_range(0, 5) == 0) begin
        drain();
        new_setting(5);
      end
      run_session(sess % 60 == 15);
      sess++;
    end

    drain();
    repeat (300) @(posedge clk);
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
